FILE: rtl/b64c_pkg.sv
`timescale 1ns / 1ps

package b64c_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [6:0] NO_SEXTET  = 7'd64;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eom;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] item;
    logic [2:0]               count;
  } batch_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == PLUS_CHAR) begin
      v = 7'd62;
    end else if (c == SLASH_CHAR) begin
      v = 7'd63;
    end else begin
      v = NO_SEXTET;
    end
    return v;
  endfunction

endpackage

FILE: rtl/b64c_engine.sv
`timescale 1ns / 1ps

module b64c_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            is_last,
  output logic            hold_valid,
  input  logic            load,
  output b64c_pkg::batch_t batch
);
  import b64c_pkg::*;

  mode_t       mode;
  logic [7:0]  hold_byte;
  logic        hold_last;
  logic [11:0] bit_store;
  logic [3:0]  bit_count;
  logic [1:0]  group_phase;
  logic [11:0] bit_store_next;
  logic [3:0]  bit_count_next;
  logic [1:0]  group_phase_next;

  logic [11:0] st;
  logic [4:0]  cnt;
  logic [1:0]  phn;
  logic [6:0]  sx;
  logic [11:0] sh;
  logic [2:0]  n;

  assign in_stall = hold_valid && !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= in_byte;
      hold_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      bit_store   <= '0;
      bit_count   <= '0;
      group_phase <= '0;
    end else if (cfg_we) begin
      mode        <= mode_t'(cfg_wdata);
      bit_store   <= '0;
      bit_count   <= '0;
      group_phase <= '0;
    end else if (load) begin
      bit_store   <= bit_store_next;
      bit_count   <= bit_count_next;
      group_phase <= group_phase_next;
    end
  end

  always_comb begin
    batch = '0;
    n     = '0;
    st    = bit_store;
    cnt   = {1'b0, bit_count};
    phn   = group_phase;
    sx    = NO_SEXTET;
    sh    = '0;
    if (mode == MODE_ENCODE) begin
      st  = {bit_store[3:0], hold_byte};
      cnt = {1'b0, bit_count} + 5'd8;
      for (int i = 0; i < 2; i++) begin
        if (cnt >= 5'd6 && cnt <= 5'd12) begin
          cnt = cnt - 5'd6;
          sh  = st >> cnt[3:0];
          if (n < 3'd4) begin
            batch.item[n[1:0]].data  = b64_char(sh[5:0]);
            batch.item[n[1:0]].valid = 1'b1;
            n = n + 3'd1;
          end
          phn = phn + 2'd1;
        end
      end
      if (hold_last && cnt >= 5'd1 && cnt <= 5'd5) begin
        sh = st << (4'd6 - cnt[3:0]);
        if (n < 3'd4) begin
          batch.item[n[1:0]].data  = b64_char(sh[5:0]);
          batch.item[n[1:0]].valid = 1'b1;
          n = n + 3'd1;
        end
        phn = phn + 2'd1;
      end
      for (int i = 0; i < 3; i++) begin
        if (hold_last && phn != 2'd0 && n < 3'd4) begin
          batch.item[n[1:0]].data  = PAD_CHAR;
          batch.item[n[1:0]].valid = 1'b1;
          n   = n + 3'd1;
          phn = phn + 2'd1;
        end
      end
    end else begin
      sx = b64_sextet(hold_byte);
      if (!sx[6]) begin
        st  = {bit_store[5:0], sx[5:0]};
        cnt = {1'b0, bit_count} + 5'd6;
        if (cnt >= 5'd8 && cnt <= 5'd12) begin
          cnt = cnt - 5'd8;
          sh  = st >> cnt[3:0];
          batch.item[0].data  = sh[7:0];
          batch.item[0].valid = 1'b1;
          n = 3'd1;
        end
      end
      if (hold_last && n == 3'd0) begin
        batch.item[0].data  = 8'd0;
        batch.item[0].valid = 1'b0;
        n = 3'd1;
      end
    end
    for (int i = 0; i < MaxResults; i++) begin
      batch.item[i].eom = hold_last && (n == 3'(i + 1));
    end
    batch.count = n;
    if (hold_last) begin
      bit_store_next   = '0;
      bit_count_next   = '0;
      group_phase_next = '0;
    end else begin
      bit_store_next   = st;
      bit_count_next   = cnt[3:0];
      group_phase_next = phn;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (load && hold_last) |=> (bit_store == '0 && bit_count == '0 && group_phase == '0))
    else $error("state not cleared after final transaction");

  assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ENCODE) |-> (bit_count == 4'd0 || bit_count == 4'd2 || bit_count == 4'd4))
    else $error("encode bit count out of sequence");

  assert property (@(posedge clk) disable iff (rst)
    (hold_valid && load) |-> (batch.count <= 3'd4))
    else $error("result count exceeds buffer depth");

endmodule

FILE: rtl/b64c_outq.sv
`timescale 1ns / 1ps

module b64c_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             hold_valid,
  output logic             load,
  input  b64c_pkg::batch_t batch,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [7:0]       out_byte,
  output logic             out_valid,
  output logic             end_of_message
);
  import b64c_pkg::*;

  result_t    q [MaxResults];
  logic [2:0] qcnt;
  logic       pop;
  logic       free;

  assign pop            = (qcnt != 3'd0) && !res_stall;
  assign free           = (qcnt == 3'd0) || (qcnt == 3'd1 && pop);
  assign load           = hold_valid && free;
  assign res_valid      = (qcnt != 3'd0);
  assign out_byte       = q[0].data;
  assign out_valid      = q[0].valid;
  assign end_of_message = q[0].eom;

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= '0;
    end else if (load) begin
      qcnt <= batch.count;
    end else if (pop) begin
      qcnt <= qcnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MaxResults; i++) begin
        q[i] <= batch.item[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    qcnt <= 3'd4)
    else $error("result buffer count out of range");

  assert property (@(posedge clk) disable iff (rst)
    (qcnt != 3'd0 && res_stall) |=> $stable(qcnt))
    else $error("buffer count moved while output stalled");

  assert property (@(posedge clk) disable iff (rst)
    (qcnt > 3'd1) |-> !load)
    else $error("batch loaded over pending results");

endmodule

FILE: rtl/base64_codec_core.sv
`timescale 1ns / 1ps

// channel   handshake             payload
// input     in_valid / in_stall   in_byte, is_last
// result    res_valid / res_stall out_byte, out_valid, end_of_message
// config    cfg_we                cfg_wdata (mode)
//
// An accepted transaction waits in the input register until the result buffer is free,
// then its results (0 to 4) load into a 4-entry result buffer and leave one per cycle
// while res_stall is low. An encode byte gives 1 or 2 results, up to 4 if final; a
// decode character gives at most 1 byte, or a single not-valid result if final.
// Reset (rst, synchronous) clears mode to encode, the bit store and both buffers.
// res_stall holds the buffer head; input is stalled only while the buffer cannot take
// the held item.

module base64_codec_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       end_of_message
);
  import b64c_pkg::*;

  logic   hold_valid;
  logic   load;
  batch_t batch;

  b64c_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .is_last    (is_last),
    .hold_valid (hold_valid),
    .load       (load),
    .batch      (batch)
  );

  b64c_outq u_outq (
    .clk            (clk),
    .rst            (rst),
    .hold_valid     (hold_valid),
    .load           (load),
    .batch          (batch),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .end_of_message (end_of_message)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import b64c_pkg::*;

  class codec_tracker;
    mode_t      mode;
    logic [11:0] bits;
    logic [3:0]  nbits;
    logic [1:0]  phase;
    string       digits;
    result_t     pending[$];
    int          mismatches;
    int          checked;
    int          accepted;

    function new();
      digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      mode = MODE_ENCODE;
      mismatches = 0;
      checked = 0;
      accepted = 0;
      clear();
    endfunction

    function void clear();
      bits = '0;
      nbits = '0;
      phase = '0;
    endfunction

    function void set_mode(mode_t m);
      mode = m;
      clear();
    endfunction

    function logic [7:0] sextet_char(logic [5:0] s);
      return digits[s];
    endfunction

    function logic [6:0] char_sextet(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (digits[i] == c) return 7'(i);
      end
      return NO_SEXTET;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      result_t     got[4];
      int          n;
      logic [6:0]  v;
      logic [11:0] t;
      n = 0;
      accepted++;
      if (mode == MODE_ENCODE) begin
        bits = {bits[3:0], b};
        nbits += 4'd8;
        while (nbits >= 4'd6) begin
          nbits -= 4'd6;
          t = bits >> nbits;
          got[n] = '{data: sextet_char(t[5:0]), valid: 1'b1, eom: 1'b0};
          n++;
          phase++;
        end
        if (last) begin
          if (nbits != 4'd0) begin
            t = bits << (4'd6 - nbits);
            got[n] = '{data: sextet_char(t[5:0]), valid: 1'b1, eom: 1'b0};
            n++;
            phase++;
          end
          while (phase != 2'd0 && n < 4) begin
            got[n] = '{data: PAD_CHAR, valid: 1'b1, eom: 1'b0};
            n++;
            phase++;
          end
        end
      end else begin
        v = char_sextet(b);
        if (v != NO_SEXTET) begin
          bits = {bits[5:0], v[5:0]};
          nbits += 4'd6;
          if (nbits >= 4'd8) begin
            nbits -= 4'd8;
            t = bits >> nbits;
            got[n] = '{data: t[7:0], valid: 1'b1, eom: 1'b0};
            n++;
          end
        end
        if (last && n == 0) begin
          got[0] = '{data: 8'h00, valid: 1'b0, eom: 1'b0};
          n = 1;
        end
      end
      if (last) begin
        got[n-1].eom = 1'b1;
        clear();
      end
      for (int i = 0; i < n; i++) pending.push_back(got[i]);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_output(logic [7:0] d, logic v, logic e);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result: byte %02h valid %0b eom %0b", d, v, e));
      end else begin
        want = pending.pop_front();
        if (want.data !== d || want.valid !== v || want.eom !== e) begin
          flag($sformatf("result %0d: expected byte %02h valid %0b eom %0b, got %02h %0b %0b",
                         checked, want.data, want.valid, want.eom, d, v, e));
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       is_last;
  logic       res_valid;
  logic       res_stall;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       end_of_message;

  codec_tracker tracker = new();

  bit steady = 1'b0;
  int holdoff_reqs = 0;
  int holdoff_seen = 0;
  int hold_left = 0;
  int mode_writes = 0;

  localparam int HoldCycles = 200;

  base64_codec_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .is_last        (is_last),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .end_of_message (end_of_message)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.check_output(out_byte, out_valid, end_of_message);
  end

  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_seen != holdoff_reqs) begin
        holdoff_seen = holdoff_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        res_stall = 1'b1;
        hold_left--;
      end else begin
        res_stall = !steady && ($urandom_range(99) < 9);
      end
    end
  end

  initial begin
    #400us;
    $display("simulation failed");
    $finish;
  end

  task automatic offer(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    is_last = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_input(b, last);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_mode(m);
    mode_writes++;
  endtask

  task automatic random_encode(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      offer(b, (i == len - 1) && ($urandom_range(9) != 0));
    end
  endtask

  task automatic random_decode(input int len);
    logic [7:0] c;
    int         r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 85) c = tracker.sextet_char(6'($urandom_range(63)));
      else if (r < 92) c = PAD_CHAR;
      else c = 8'($urandom_range(255));
      offer(c, (i == len - 1) && ($urandom_range(9) != 0));
    end
  endtask

  initial begin
    mode_t plan[8];
    int    sent;
    plan = '{MODE_ENCODE, MODE_DECODE, MODE_ENCODE, MODE_ENCODE,
             MODE_DECODE, MODE_DECODE, MODE_ENCODE, MODE_DECODE};
    cfg_we = 1'b0;
    cfg_wdata = MODE_ENCODE;
    in_valid = 1'b0;
    in_byte = 8'h00;
    is_last = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    offer(8'h00, 1'b1);
    offer(8'hFF, 1'b1);
    offer(8'h66, 1'b0);
    offer(8'h6F, 1'b1);
    offer(8'h00, 1'b0);
    offer(8'hFF, 1'b0);
    offer(8'h80, 1'b1);
    settle();

    write_mode(MODE_DECODE);
    offer("Z", 1'b0);
    offer("m", 1'b0);
    offer("9", 1'b0);
    offer("v", 1'b1);
    offer("Z", 1'b0);
    offer("g", 1'b0);
    offer(PAD_CHAR, 1'b0);
    offer(PAD_CHAR, 1'b1);
    offer(8'h00, 1'b1);
    offer(8'hFF, 1'b0);
    offer(8'h2A, 1'b0);
    offer(PLUS_CHAR, 1'b0);
    offer(SLASH_CHAR, 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      write_mode(plan[p]);
      steady = (p == 3);
      if (p == 2) holdoff_reqs++;
      sent = 0;
      while (sent < 34) begin
        if (plan[p] == MODE_ENCODE) begin
          r_len_encode: begin
            int len;
            len = $urandom_range(9, 1);
            random_encode(len);
            sent += len;
          end
        end else begin
          r_len_decode: begin
            int len;
            len = $urandom_range(12, 1);
            random_decode(len);
            sent += len;
          end
        end
      end
      settle();
      steady = 1'b0;
    end

    repeat (30) @(negedge clk);
    if (tracker.pending.size() != 0) begin
      tracker.flag($sformatf("%0d expected results never arrived", tracker.pending.size()));
    end
    $display("covered %0d input transactions and %0d results over %0d mode writes,",
             tracker.accepted, tracker.checked, mode_writes);
    $display("with a %0d-cycle result hold-off and one phase without idling",
             HoldCycles);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: base64_codec_core.f
rtl/b64c_pkg.sv
rtl/b64c_engine.sv
rtl/b64c_outq.sv
rtl/base64_codec_core.sv
bench/tb_top.sv
